>>> rtl/assert_macros.svh
// Assertion macros shared by the RTL of the point-to-line distance block.
// Depends on nothing; included by the files that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Checks a property at each rising clock edge while reset is released.
`define CHECK_PROP(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Checks that a request refused by the receiver is held unchanged in the next cycle.
`define CHECK_HOLD(lbl, clk, rst_n, vld, rdy, data, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) \
        vld && !rdy |=> vld && $stable(data)) else $error(msg);
`endif

>>> rtl/p2ld_pkg.sv
// Package of the point-to-line distance block: default sizes and port constants.
// Depends on nothing; imported by every module of the block.
`default_nettype none
package p2ld_pkg;
    localparam int COORD_WIDTH_DEF = 32;
    localparam int LEN_WIDTH       = 16;
    localparam int NUM_COORDS      = 9;
    localparam logic [LEN_WIDTH-1:0] LEN_RESET = LEN_WIDTH'(1);
endpackage
`default_nettype wire

>>> rtl/p2ld_front.sv
// Front pipeline: differences, cross products, squared lengths and the operand select.
// Depends on p2ld_pkg; feeds the first square root cell.
`default_nettype none
`include "assert_macros.svh"
module p2ld_front
    import p2ld_pkg::*;
#(
    parameter int CW = COORD_WIDTH_DEF
)
(
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      in_valid,
    output logic                           in_ready,
    input  wire logic [NUM_COORDS*CW-1:0]  in_data,
    input  wire logic [LEN_WIDTH-1:0]      min_len,
    output logic                           out_valid,
    input  wire logic                      out_ready,
    output logic [4*CW+3:0]                out_num,
    output logic [2*CW+1:0]                out_den,
    output logic                           out_degen
);
    localparam int DW  = CW + 1;
    localparam int PW  = 2 * DW;
    localparam int CRW = PW + 1;
    localparam int AW  = CRW - 1;
    localparam int LW  = 2 * CW + 2;
    localparam int H   = CW + 1;
    localparam int HW  = AW - H;
    localparam int NW  = 4 * CW + 4;

    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg;
    logic r1, r2, r3, r4, r5;

    logic signed [DW-1:0]  u1_reg [3];
    logic signed [DW-1:0]  w1_reg [3];
    logic signed [DW-1:0]  u1_next [3];
    logic signed [DW-1:0]  w1_next [3];
    logic signed [PW-1:0]  m2_reg [12];
    logic signed [PW-1:0]  m2_next [12];
    logic signed [CRW-1:0] c3_reg [3];
    logic signed [CRW-1:0] c3_next [3];
    logic [LW-1:0]         l3_reg, l3_next, q3_reg, q3_next;
    logic [2*H-1:0]        ll4_reg [3];
    logic [2*H-1:0]        ll4_next [3];
    logic [H+HW-1:0]       hl4_reg [3];
    logic [H+HW-1:0]       hl4_next [3];
    logic [2*HW-1:0]       hh4_reg [3];
    logic [2*HW-1:0]       hh4_next [3];
    logic [AW-1:0]         mag [3];
    logic [LW-1:0]         l4_reg, q4_reg;
    logic                  g4_reg, g4_next;
    logic [NW-1:0]         num5_reg, num5_next;
    logic [LW-1:0]         den5_reg, den5_next;
    logic                  g5_reg;
    logic [NW-1:0]         sum5;

    assign r5 = !v5_reg || out_ready;
    assign r4 = !v4_reg || r5;
    assign r3 = !v3_reg || r4;
    assign r2 = !v2_reg || r3;
    assign r1 = !v1_reg || r2;
    assign in_ready = r1;

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            u1_next[k] = DW'($signed(in_data[k*CW +: CW]))
                       - DW'($signed(in_data[(k+3)*CW +: CW]));
            w1_next[k] = DW'($signed(in_data[(k+6)*CW +: CW]))
                       - DW'($signed(in_data[(k+3)*CW +: CW]));
        end
        m2_next[0]  = PW'(u1_reg[1]) * PW'(w1_reg[2]);
        m2_next[1]  = PW'(u1_reg[2]) * PW'(w1_reg[1]);
        m2_next[2]  = PW'(u1_reg[2]) * PW'(w1_reg[0]);
        m2_next[3]  = PW'(u1_reg[0]) * PW'(w1_reg[2]);
        m2_next[4]  = PW'(u1_reg[0]) * PW'(w1_reg[1]);
        m2_next[5]  = PW'(u1_reg[1]) * PW'(w1_reg[0]);
        for (int k = 0; k < 3; k++)
        begin
            m2_next[6+k] = PW'(w1_reg[k]) * PW'(w1_reg[k]);
            m2_next[9+k] = PW'(u1_reg[k]) * PW'(u1_reg[k]);
        end
        for (int k = 0; k < 3; k++)
        begin
            c3_next[k] = CRW'(m2_reg[2*k]) - CRW'(m2_reg[2*k+1]);
        end
        l3_next = LW'($unsigned(m2_reg[6])) + LW'($unsigned(m2_reg[7]))
                + LW'($unsigned(m2_reg[8]));
        q3_next = LW'($unsigned(m2_reg[9])) + LW'($unsigned(m2_reg[10]))
                + LW'($unsigned(m2_reg[11]));
        for (int k = 0; k < 3; k++)
        begin
            mag[k]      = c3_reg[k][CRW-1] ? AW'(-c3_reg[k]) : AW'(c3_reg[k]);
            ll4_next[k] = (2*H)'(mag[k][H-1:0]) * (2*H)'(mag[k][H-1:0]);
            hl4_next[k] = (H+HW)'(mag[k][AW-1:H]) * (H+HW)'(mag[k][H-1:0]);
            hh4_next[k] = (2*HW)'(mag[k][AW-1:H]) * (2*HW)'(mag[k][AW-1:H]);
        end
        g4_next = (l3_reg == '0) || (l3_reg < (LW'(min_len) * LW'(min_len)));
        sum5 = '0;
        for (int k = 0; k < 3; k++)
        begin
            sum5 = sum5 + (NW'(hh4_reg[k]) << (2*H)) + (NW'(hl4_reg[k]) << (H+1))
                 + NW'(ll4_reg[k]);
        end
        num5_next = g4_reg ? NW'(q4_reg) : sum5;
        den5_next = g4_reg ? LW'(1) : l4_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end
        else
        begin
            if (r1) v1_reg <= in_valid;
            if (r2) v2_reg <= v1_reg;
            if (r3) v3_reg <= v2_reg;
            if (r4) v4_reg <= v3_reg;
            if (r5) v5_reg <= v4_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (r1)
        begin
            u1_reg <= u1_next;
            w1_reg <= w1_next;
        end
        if (r2)
        begin
            m2_reg <= m2_next;
        end
        if (r3)
        begin
            c3_reg <= c3_next;
            l3_reg <= l3_next;
            q3_reg <= q3_next;
        end
        if (r4)
        begin
            ll4_reg <= ll4_next;
            hl4_reg <= hl4_next;
            hh4_reg <= hh4_next;
            l4_reg  <= l3_reg;
            q4_reg  <= q3_reg;
            g4_reg  <= g4_next;
        end
        if (r5)
        begin
            num5_reg <= num5_next;
            den5_reg <= den5_next;
            g5_reg   <= g4_reg;
        end
    end

    assign out_valid = v5_reg;
    assign out_num   = num5_reg;
    assign out_den   = den5_reg;
    assign out_degen = g5_reg;

    `CHECK_PROP(degen_unit_den, clk, rst_n, v5_reg && g5_reg |-> den5_reg == LW'(1), "degenerate request must divide by one")
endmodule
`default_nettype wire

>>> rtl/p2ld_cell.sv
// One cell of the square root chain: settles one result bit of sqrt(num / den).
// Depends on p2ld_pkg; instantiated in a row by the top level.
`default_nettype none
`include "assert_macros.svh"
module p2ld_cell
    import p2ld_pkg::*;
#(
    parameter int CW  = COORD_WIDTH_DEF,
    parameter int BIT = 0
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire logic [4*CW+3:0]   in_rem,
    input  wire logic [4*CW+3:0]   in_prod,
    input  wire logic [2*CW+1:0]   in_den,
    input  wire logic [CW:0]       in_root,
    input  wire logic              in_degen,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output logic [4*CW+3:0]        out_rem,
    output logic [4*CW+3:0]        out_prod,
    output logic [2*CW+1:0]        out_den,
    output logic [CW:0]            out_root,
    output logic                   out_degen
);
    localparam int NW = 4 * CW + 4;
    localparam int XW = NW + 1;
    localparam int OW = CW + 1;
    localparam logic [OW-1:0] LOW_MASK = {OW{1'b1}} >> (OW - BIT);

    logic          v_reg;
    logic          en;
    logic [XW-1:0] delta;
    logic          take;
    logic [NW-1:0] rem_reg, rem_next, prod_reg, prod_next;
    logic [2*CW+1:0] den_reg;
    logic [OW-1:0] root_reg, root_next;
    logic          degen_reg;

    assign en       = !v_reg || out_ready;
    assign in_ready = en;

    // Trying bit b on root r costs (2 r 2^b + 2^2b) times den; prod holds r times den.
    always_comb
    begin
        delta     = (XW'(in_prod) << (BIT + 1)) + (XW'(in_den) << (2 * BIT));
        take      = delta <= XW'(in_rem);
        rem_next  = take ? NW'(XW'(in_rem) - delta) : in_rem;
        prod_next = take ? in_prod + (NW'(in_den) << BIT) : in_prod;
        root_next = take ? (in_root | (OW'(1) << BIT)) : in_root;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= 1'b0;
        end
        else if (en)
        begin
            v_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg   <= rem_next;
            prod_reg  <= prod_next;
            den_reg   <= in_den;
            root_reg  <= root_next;
            degen_reg <= in_degen;
        end
    end

    assign out_valid = v_reg;
    assign out_rem   = rem_reg;
    assign out_prod  = prod_reg;
    assign out_den   = den_reg;
    assign out_root  = root_reg;
    assign out_degen = degen_reg;

    `CHECK_PROP(low_bits_open, clk, rst_n, v_reg |-> (root_reg & LOW_MASK) == '0, "bits below this cell must still be clear")
endmodule
`default_nettype wire

>>> rtl/point_to_line_distance_3d_core.sv
// Top level of the point-to-line distance block: register, front pipeline, root cell row.
// Depends on p2ld_pkg, p2ld_front and p2ld_cell.
//
//  Channel   Signals                          Direction  Contents
//  s_        s_tvalid s_tready s_tdata        in         point, start, end coordinates
//  m_        m_tvalid m_tready m_tdata m_tuser out        distance, degenerate flag
//  cfg_      cfg_valid cfg_ready cfg_data     in         minimum line length
//
// One request enters per cycle unless the output stalls; it passes 5 front stages
// and then COORD_WIDTH + 1 root cells, each of which settles one result bit.
// Reset clears all valid flags and sets the minimum line length to one.
// A stalled output holds its stage; bubbles further up keep being filled.
`default_nettype none
`include "assert_macros.svh"
module point_to_line_distance_3d_core
    import p2ld_pkg::*;
#(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF
)
(
    input  wire logic                                         clk,
    input  wire logic                                         rst_n,
    input  wire logic                                         s_tvalid,
    output logic                                              s_tready,
    // point_x, point_y, point_z, start_x, start_y, start_z, end_x, end_y, end_z
    input  wire logic [((NUM_COORDS*COORD_WIDTH+7)/8)*8-1:0] s_tdata,
    output logic                                              m_tvalid,
    input  wire logic                                         m_tready,
    // distance
    output logic [((COORD_WIDTH+8)/8)*8-1:0]                  m_tdata,
    // degenerate_line
    output logic [0:0]                                        m_tuser,
    input  wire logic                                         cfg_valid,
    output logic                                              cfg_ready,
    input  wire logic [LEN_WIDTH-1:0]                         cfg_data
);
    localparam int CW  = COORD_WIDTH;
    localparam int OW  = CW + 1;
    localparam int NW  = 4 * CW + 4;
    localparam int LW  = 2 * CW + 2;
    localparam int OTW = ((CW + 8) / 8) * 8;

    logic [LEN_WIDTH-1:0] min_len_reg;
    logic                 vld   [OW+1];
    logic                 rdy   [OW+1];
    logic [NW-1:0]        rem   [OW+1];
    logic [NW-1:0]        prod  [OW+1];
    logic [LW-1:0]        den   [OW+1];
    logic [OW-1:0]        root  [OW+1];
    logic                 degen [OW+1];

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_len_reg <= LEN_RESET;
        end
        else if (cfg_valid)
        begin
            min_len_reg <= cfg_data;
        end
    end

    p2ld_front #(.CW(CW)) u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_data   (s_tdata[NUM_COORDS*CW-1:0]),
        .min_len   (min_len_reg),
        .out_valid (vld[0]),
        .out_ready (rdy[0]),
        .out_num   (rem[0]),
        .out_den   (den[0]),
        .out_degen (degen[0])
    );

    assign prod[0] = '0;
    assign root[0] = '0;

    for (genvar k = 0; k < OW; k++)
    begin : g_cell
        p2ld_cell #(.CW(CW), .BIT(OW - 1 - k)) u_cell
        (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (vld[k]),
            .in_ready  (rdy[k]),
            .in_rem    (rem[k]),
            .in_prod   (prod[k]),
            .in_den    (den[k]),
            .in_root   (root[k]),
            .in_degen  (degen[k]),
            .out_valid (vld[k+1]),
            .out_ready (rdy[k+1]),
            .out_rem   (rem[k+1]),
            .out_prod  (prod[k+1]),
            .out_den   (den[k+1]),
            .out_root  (root[k+1]),
            .out_degen (degen[k+1])
        );
    end

    assign rdy[OW]    = m_tready;
    assign m_tvalid   = vld[OW];
    assign m_tdata    = OTW'(root[OW]);
    assign m_tuser[0] = degen[OW];

    `CHECK_PROP(full_only_when_stalled, clk, rst_n, !s_tready |-> m_tvalid && !m_tready, "input refused while the output is not stalled")
    `CHECK_HOLD(result_held, clk, rst_n, m_tvalid, m_tready, {m_tdata, m_tuser}, "a refused result must stay unchanged")
endmodule
`default_nettype wire
